### hw/rtl/mdbd_pkg.sv
// package for the mixed des block decoder: tables, codes and helper functions
package mdbd_pkg;

  // blocks at the head of a file that are always decoded
  localparam logic [4:0] HEAD_BLOCKS = 5'd20;

  // configuration register indexes
  localparam logic [1:0] REG_CYCLE_DIGITS = 2'd0;
  localparam logic [1:0] REG_HEAD_ONLY    = 2'd1;
  localparam logic [1:0] REG_NAME_MODE    = 2'd2;

  // per-item operation carried from the input stage to the result stage
  localparam logic [1:0] OP_PASS    = 2'd0;
  localparam logic [1:0] OP_DECODE  = 2'd1;
  localparam logic [1:0] OP_SHUFFLE = 2'd2;

  // bit permutation tables, 1-based source positions, msb first
  localparam logic [6:0] PERM_IN [64] = '{
    7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
    7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
    7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
  };

  localparam logic [6:0] PERM_OUT [64] = '{
    7'd40, 7'd8,  7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
    7'd39, 7'd7,  7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
    7'd38, 7'd6,  7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
    7'd37, 7'd5,  7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
    7'd36, 7'd4,  7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
    7'd35, 7'd3,  7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
    7'd34, 7'd2,  7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
    7'd33, 7'd1,  7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25
  };

  localparam logic [5:0] PERM_ROUND [32] = '{
    6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
    6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
    6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
    6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
  };

  // substitution tables for the round function
  localparam logic [7:0] SBOX [4][64] = '{
    '{
      8'hef,8'h03,8'h41,8'hfd,8'hd8,8'h74,8'h1e,8'h47,
      8'h26,8'hef,8'hfb,8'h22,8'hb3,8'hd8,8'h84,8'h1e,
      8'h39,8'hac,8'ha7,8'h60,8'h62,8'hc1,8'hcd,8'hba,
      8'h5c,8'h96,8'h90,8'h59,8'h05,8'h3b,8'h7a,8'h85,
      8'h40,8'hfd,8'h1e,8'hc8,8'he7,8'h8a,8'h8b,8'h21,
      8'hda,8'h43,8'h64,8'h9f,8'h2d,8'h14,8'hb1,8'h72,
      8'hf5,8'h5b,8'hc8,8'hb6,8'h9c,8'h37,8'h76,8'hec,
      8'h39,8'ha0,8'ha3,8'h05,8'h52,8'h6e,8'h0f,8'hd9
    },
    '{
      8'ha7,8'hdd,8'h0d,8'h78,8'h9e,8'h0b,8'he3,8'h95,
      8'h60,8'h36,8'h36,8'h4f,8'hf9,8'h60,8'h5a,8'ha3,
      8'h11,8'h24,8'hd2,8'h87,8'hc8,8'h52,8'h75,8'hec,
      8'hbb,8'hc1,8'h4c,8'hba,8'h24,8'hfe,8'h8f,8'h19,
      8'hda,8'h13,8'h66,8'haf,8'h49,8'hd0,8'h90,8'h06,
      8'h8c,8'h6a,8'hfb,8'h91,8'h37,8'h8d,8'h0d,8'h78,
      8'hbf,8'h49,8'h11,8'hf4,8'h23,8'he5,8'hce,8'h3b,
      8'h55,8'hbc,8'ha2,8'h57,8'he8,8'h22,8'h74,8'hce
    },
    '{
      8'h2c,8'hea,8'hc1,8'hbf,8'h4a,8'h24,8'h1f,8'hc2,
      8'h79,8'h47,8'ha2,8'h7c,8'hb6,8'hd9,8'h68,8'h15,
      8'h80,8'h56,8'h5d,8'h01,8'h33,8'hfd,8'hf4,8'hae,
      8'hde,8'h30,8'h07,8'h9b,8'he5,8'h83,8'h9b,8'h68,
      8'h49,8'hb4,8'h2e,8'h83,8'h1f,8'hc2,8'hb5,8'h7c,
      8'ha2,8'h19,8'hd8,8'he5,8'h7c,8'h2f,8'h83,8'hda,
      8'hf7,8'h6b,8'h90,8'hfe,8'hc4,8'h01,8'h5a,8'h97,
      8'h61,8'ha6,8'h3d,8'h40,8'h0b,8'h58,8'he6,8'h3d
    },
    '{
      8'h4d,8'hd1,8'hb2,8'h0f,8'h28,8'hbd,8'he4,8'h78,
      8'hf6,8'h4a,8'h0f,8'h93,8'h8b,8'h17,8'hd1,8'ha4,
      8'h3a,8'hec,8'hc9,8'h35,8'h93,8'h56,8'h7e,8'hcb,
      8'h55,8'h20,8'ha0,8'hfe,8'h6c,8'h89,8'h17,8'h62,
      8'h17,8'h62,8'h4b,8'hb1,8'hb4,8'hde,8'hd1,8'h87,
      8'hc9,8'h14,8'h3c,8'h4a,8'h7e,8'ha8,8'he2,8'h7d,
      8'ha0,8'h9f,8'hf6,8'h5c,8'h6a,8'h09,8'h8d,8'hf0,
      8'h0f,8'he3,8'h53,8'h25,8'h95,8'h36,8'h28,8'hcb
    }
  };

  // initial permutation, pure wiring
  function automatic logic [63:0] perm_in64(input logic [63:0] v);
    logic [63:0] r;
    logic [5:0]  src;
    r = '0;
    for (int k = 0; k < 64; k++) begin
      src = 6'(PERM_IN[k] - 7'd1);
      r[6'(63 - k)] = v[6'd63 - src];
    end
    return r;
  endfunction

  // final permutation, pure wiring
  function automatic logic [63:0] perm_out64(input logic [63:0] v);
    logic [63:0] r;
    logic [5:0]  src;
    r = '0;
    for (int k = 0; k < 64; k++) begin
      src = 6'(PERM_OUT[k] - 7'd1);
      r[6'(63 - k)] = v[6'd63 - src];
    end
    return r;
  endfunction

  // 32-bit permutation inside the round
  function automatic logic [31:0] perm_round32(input logic [31:0] s);
    logic [31:0] r;
    logic [4:0]  src;
    r = '0;
    for (int k = 0; k < 32; k++) begin
      src = 5'(PERM_ROUND[k] - 6'd1);
      r[5'(31 - k)] = s[5'd31 - src];
    end
    return r;
  endfunction

  // swap of the last byte by the fixed pair list
  function automatic logic [7:0] pair_swap(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00:   r = 8'h2b;
      8'h2b:   r = 8'h00;
      8'h01:   r = 8'h68;
      8'h68:   r = 8'h01;
      8'h48:   r = 8'h77;
      8'h77:   r = 8'h48;
      8'h60:   r = 8'hff;
      8'hff:   r = 8'h60;
      8'h6c:   r = 8'h80;
      8'h80:   r = 8'h6c;
      8'hb9:   r = 8'hc0;
      8'hc0:   r = 8'hb9;
      8'heb:   r = 8'hfe;
      8'hfe:   r = 8'heb;
      default: r = a;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/mdbd_decode.sv
// decode datapath: initial permutation, one keyless round, final permutation
module mdbd_decode (
  input  logic [63:0] din,
  output logic [63:0] dout
);

  logic [63:0] ip;
  logic [7:0]  b4, b5, b6, b7;
  logic [5:0]  e [8];
  logic [31:0] s;
  logic [31:0] p;
  logic [63:0] rnd;

  // initial permutation
  assign ip = mdbd_pkg::perm_in64(din);
  assign b4 = ip[31:24];
  assign b5 = ip[23:16];
  assign b6 = ip[15:8];
  assign b7 = ip[7:0];

  // expansion of the right half into eight 6-bit indices
  assign e[0] = {b7[0], b4[7:3]};
  assign e[1] = {b4[4:0], b5[7]};
  assign e[2] = {b4[0], b5[7:3]};
  assign e[3] = {b5[4:0], b6[7]};
  assign e[4] = {b5[0], b6[7:3]};
  assign e[5] = {b6[4:0], b7[7]};
  assign e[6] = {b6[0], b7[7:3]};
  assign e[7] = {b7[4:0], b4[7]};

  // table lookups, high nibble from the even index and low from the odd one
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      s[31 - 8*k -: 4] = mdbd_pkg::SBOX[k][e[2*k]][7:4];
      s[27 - 8*k -: 4] = mdbd_pkg::SBOX[k][e[2*k + 1]][3:0];
    end
  end

  // round permutation folded into the left half
  assign p    = mdbd_pkg::perm_round32(s);
  assign rnd  = {ip[63:32] ^ p, ip[31:0]};

  // final permutation
  assign dout = mdbd_pkg::perm_out64(rnd);

endmodule

### hw/rtl/mixed_des_block_decoder.sv
// top level of the mixed des block decoder: mode counters, input stage, result stage
//
//  channel | signals                                  | handshake
//  --------+------------------------------------------+------------------------------
//  in      | data_block, last_block                   | in_valid / in_stall
//  out     | plain_block, last_out                    | out_valid / out_stall
//  cfg     | cfg_index, cfg_data                      | cfg_valid / cfg_ready (always 1)
//
// One item per cycle sustained while the output does not stall; an accepted item
// is held in the input register and then shown in the result register.
// The mode counters are updated as an item is accepted, so consecutive items
// see each other's updates with no gap. Reset restores the register defaults
// and clears all counters and valid flags. A stall on the output holds the
// result register and backs up through the input register to in_stall.
module mixed_des_block_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] data_block,
  input  logic        last_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] plain_block,
  output logic        last_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  // configuration registers
  logic [3:0] cycle_digits;
  logic       head_only_mode;
  logic       name_mode;

  // mode counters
  logic [4:0] block_count, block_count_next;
  logic [4:0] cycle_phase, cycle_phase_next;
  logic [2:0] shuffle_count, shuffle_count_next;

  // input stage
  logic        s_valid;
  logic [63:0] s_data;
  logic [1:0]  s_op;
  logic        s_last;

  logic        in_fire;
  logic        out_adv;
  logic [4:0]  cycle_len;
  logic [5:0]  phase_inc;
  logic        full_mode;
  logic        head_hit;
  logic [1:0]  op_sel;
  logic [63:0] data_sel;
  logic [63:0] dec_data;
  logic [63:0] res_data;

  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_digits   <= 4'd0;
      head_only_mode <= 1'b1;
      name_mode      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mdbd_pkg::REG_CYCLE_DIGITS: cycle_digits   <= cfg_data;
        mdbd_pkg::REG_HEAD_ONLY:    head_only_mode <= cfg_data[0];
        mdbd_pkg::REG_NAME_MODE:    name_mode      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // handshake: result register frees up when empty or taken
  assign out_adv  = !out_valid || !out_stall;
  assign in_stall = s_valid && !out_adv;
  assign in_fire  = in_valid && !in_stall;

  // adjusted cycle length from the digit count
  always_comb begin
    if (cycle_digits < 4'd3) begin
      cycle_len = 5'd3;
    end else if (cycle_digits < 4'd5) begin
      cycle_len = 5'({1'b0, cycle_digits} + 5'd1);
    end else if (cycle_digits < 4'd7) begin
      cycle_len = 5'({1'b0, cycle_digits} + 5'd9);
    end else begin
      cycle_len = 5'({1'b0, cycle_digits} + 5'd15);
    end
  end

  // per-item decision and counter updates
  always_comb begin
    full_mode          = !head_only_mode;
    head_hit           = block_count < mdbd_pkg::HEAD_BLOCKS;
    phase_inc          = {1'b0, cycle_phase} + 6'd1;
    block_count_next   = block_count;
    cycle_phase_next   = cycle_phase;
    shuffle_count_next = shuffle_count;
    op_sel             = mdbd_pkg::OP_PASS;
    data_sel           = data_block;
    if (name_mode) begin
      // nibble swap inside each byte, then decode
      for (int k = 0; k < 8; k++) begin
        data_sel[8*k +: 8] = {data_block[8*k +: 4], data_block[8*k + 4 +: 4]};
      end
      op_sel = mdbd_pkg::OP_DECODE;
    end else begin
      if (head_hit || (full_mode && cycle_phase == 5'd0)) begin
        op_sel = mdbd_pkg::OP_DECODE;
      end else if (shuffle_count == 3'd7 && full_mode) begin
        op_sel             = mdbd_pkg::OP_SHUFFLE;
        shuffle_count_next = 3'd1;
      end else begin
        shuffle_count_next = shuffle_count + 3'd1;
      end
      if (head_hit) begin
        block_count_next = block_count + 5'd1;
      end
      cycle_phase_next = (phase_inc >= {1'b0, cycle_len}) ? 5'd0 : phase_inc[4:0];
    end
    // end of file restarts all counters
    if (last_block) begin
      block_count_next   = 5'd0;
      cycle_phase_next   = 5'd0;
      shuffle_count_next = 3'd0;
    end
  end

  // counters advance on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      block_count   <= 5'd0;
      cycle_phase   <= 5'd0;
      shuffle_count <= 3'd0;
    end else if (in_fire) begin
      block_count   <= block_count_next;
      cycle_phase   <= cycle_phase_next;
      shuffle_count <= shuffle_count_next;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (out_adv || !s_valid) begin
      s_valid <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s_data <= data_sel;
      s_op   <= op_sel;
      s_last <= last_block;
    end
  end

  // decode datapath
  mdbd_decode u_decode (
    .din  (s_data),
    .dout (dec_data)
  );

  // result select
  always_comb begin
    case (s_op)
      mdbd_pkg::OP_DECODE:  res_data = dec_data;
      mdbd_pkg::OP_SHUFFLE: res_data = {s_data[39:32], s_data[31:24], s_data[15:8],
                                        s_data[63:56], s_data[55:48], s_data[47:40],
                                        s_data[23:16], mdbd_pkg::pair_swap(s_data[7:0])};
      default:              res_data = s_data;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s_valid) begin
      plain_block <= res_data;
      last_out    <= s_last;
    end
  end

endmodule
